// ===== rtl/core/dtaq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtaq_pkg: shared types and constants of the dual threshold alarm qualifier
// Item layouts, event and alert codes, register map and queue depths.
// ----------------------------------------------------------------------------
package dtaq_pkg;

  // Channels that have registers and an event field in the result.
  localparam int unsigned MAX_CH = 2;

  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 5;

  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;

  localparam logic [2:0] REG_THRESHOLD_ONE     = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_TWO     = 3'd1;
  localparam logic [2:0] REG_QUALIFY_DELAY_ONE = 3'd2;
  localparam logic [2:0] REG_QUALIFY_DELAY_TWO = 3'd3;
  localparam logic [2:0] REG_REMINDER_PERIOD   = 3'd4;
  localparam logic [2:0] REG_REPORT_ENABLE_ONE = 3'd5;
  localparam logic [2:0] REG_REPORT_ENABLE_TWO = 3'd6;

  localparam logic [VALUE_W-1:0]  THRESHOLD_RESET = 16'hFFFF;
  localparam logic [PERIOD_W-1:0] REMINDER_RESET  = 32'd60000;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_START    = 2'd1,
    EV_CONTINUE = 2'd2,
    EV_END      = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    LVL_OK       = 2'd0,
    LVL_ELEVATED = 2'd1,
    LVL_DANGER   = 2'd2
  } level_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sample_value;
    logic [TIME_W-1:0]  time_ms;
    logic               sample_ok;
  } sample_t;

  typedef struct packed {
    level_t             alert_level;
    event_t             event_one_kind;
    event_t             event_two_kind;
    logic [VALUE_W-1:0] event_value;
  } result_t;

  // A classified item on its way from the front to the back.
  typedef struct packed {
    logic [VALUE_W-1:0] sample_value;
    logic [TIME_W-1:0]  time_ms;
    logic [MAX_CH-1:0]  above;
  } work_t;

  typedef struct packed {
    logic [MAX_CH-1:0][VALUE_W-1:0]  threshold;
    logic [MAX_CH-1:0][PERIOD_W-1:0] qualify_delay;
    logic [PERIOD_W-1:0]             reminder_period;
    logic [MAX_CH-1:0]               report_enable;
  } cfg_t;

endpackage

// ===== rtl/core/dtaq_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtaq_fifo: small synchronous queue
// Register-based first-in first-out buffer; the head is shown while not empty.
// ----------------------------------------------------------------------------
module dtaq_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/core/dtaq_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtaq_regs: configuration register file
// APB-style slave holding thresholds, delays, reminder period and enables.
// ----------------------------------------------------------------------------
module dtaq_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtaq_pkg::ADDR_W-1:0]   paddr,
  input  logic [dtaq_pkg::DATA_W-1:0]   pwdata,
  output logic [dtaq_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output dtaq_pkg::cfg_t                cfg
);

  dtaq_pkg::cfg_t regs;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[dtaq_pkg::ADDR_W-1:2];
  assign cfg     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.threshold[0]     <= dtaq_pkg::THRESHOLD_RESET;
      regs.threshold[1]     <= dtaq_pkg::THRESHOLD_RESET;
      regs.qualify_delay[0] <= '0;
      regs.qualify_delay[1] <= '0;
      regs.reminder_period  <= dtaq_pkg::REMINDER_RESET;
      regs.report_enable    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        dtaq_pkg::REG_THRESHOLD_ONE:     regs.threshold[0]     <= pwdata[15:0];
        dtaq_pkg::REG_THRESHOLD_TWO:     regs.threshold[1]     <= pwdata[15:0];
        dtaq_pkg::REG_QUALIFY_DELAY_ONE: regs.qualify_delay[0] <= pwdata;
        dtaq_pkg::REG_QUALIFY_DELAY_TWO: regs.qualify_delay[1] <= pwdata;
        dtaq_pkg::REG_REMINDER_PERIOD:   regs.reminder_period  <= pwdata;
        dtaq_pkg::REG_REPORT_ENABLE_ONE: regs.report_enable[0] <= pwdata[0];
        dtaq_pkg::REG_REPORT_ENABLE_TWO: regs.report_enable[1] <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dtaq_pkg::REG_THRESHOLD_ONE:     prdata = {16'd0, regs.threshold[0]};
      dtaq_pkg::REG_THRESHOLD_TWO:     prdata = {16'd0, regs.threshold[1]};
      dtaq_pkg::REG_QUALIFY_DELAY_ONE: prdata = regs.qualify_delay[0];
      dtaq_pkg::REG_QUALIFY_DELAY_TWO: prdata = regs.qualify_delay[1];
      dtaq_pkg::REG_REMINDER_PERIOD:   prdata = regs.reminder_period;
      dtaq_pkg::REG_REPORT_ENABLE_ONE: prdata = {31'd0, regs.report_enable[0]};
      dtaq_pkg::REG_REPORT_ENABLE_TWO: prdata = {31'd0, regs.report_enable[1]};
      default:                         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/dtaq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtaq_front: sample intake and classification
// Drops invalid samples and compares valid ones against each threshold.
// ----------------------------------------------------------------------------
module dtaq_front #(
  parameter int unsigned NUM_ACT = 2
) (
  input  logic              push,
  input  dtaq_pkg::sample_t sample,
  output logic              full,
  input  dtaq_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              q_push,
  output dtaq_pkg::work_t   q_data
);

  assign full   = q_full;
  // An invalid sample is still taken from the channel, it simply goes no further.
  assign q_push = push && !q_full && sample.sample_ok;

  always_comb begin
    q_data.sample_value = sample.sample_value;
    q_data.time_ms      = sample.time_ms;
    for (int c = 0; c < dtaq_pkg::MAX_CH; c++) begin
      q_data.above[c] = (c < NUM_ACT) && (sample.sample_value > cfg.threshold[c]);
    end
  end

endmodule

// ===== rtl/core/dtaq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtaq_back: per-channel alarm state and result assembly
// Runs the delay, crossing and reminder logic and forms one result per item.
// ----------------------------------------------------------------------------
module dtaq_back #(
  parameter int unsigned NUM_ACT = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  dtaq_pkg::cfg_t    cfg,
  input  logic              q_empty,
  input  dtaq_pkg::work_t   q_data,
  output logic              q_pop,
  input  logic              out_full,
  output logic              out_push,
  output dtaq_pkg::result_t out_data
);

  localparam int unsigned SUM_W = dtaq_pkg::TIME_W + 1;

  logic [dtaq_pkg::MAX_CH-1:0]                      crossed;
  logic [dtaq_pkg::MAX_CH-1:0]                      crossed_next;
  logic [dtaq_pkg::MAX_CH-1:0]                      running;
  logic [dtaq_pkg::MAX_CH-1:0]                      running_next;
  logic [dtaq_pkg::MAX_CH-1:0][dtaq_pkg::TIME_W-1:0] dstart;
  logic [dtaq_pkg::MAX_CH-1:0][dtaq_pkg::TIME_W-1:0] dstart_next;
  logic [dtaq_pkg::MAX_CH-1:0][dtaq_pkg::TIME_W-1:0] lastrem;
  logic [dtaq_pkg::MAX_CH-1:0][dtaq_pkg::TIME_W-1:0] lastrem_next;
  logic [dtaq_pkg::MAX_CH-1:0][SUM_W-1:0]            delay_sum;
  logic [dtaq_pkg::MAX_CH-1:0][SUM_W-1:0]            remind_sum;
  logic [dtaq_pkg::MAX_CH-1:0]                      has_delay;
  logic [dtaq_pkg::MAX_CH-1:0]                      act;
  dtaq_pkg::event_t                                 ev [dtaq_pkg::MAX_CH];
  logic [SUM_W-1:0]                                 t_ext;
  logic                                             go;

  assign go       = !q_empty && !out_full;
  assign q_pop    = go;
  assign out_push = go;
  assign t_ext    = {1'b0, q_data.time_ms};

  // Sums are one bit wider than a timestamp so they never wrap.
  always_comb begin
    for (int c = 0; c < dtaq_pkg::MAX_CH; c++) begin
      delay_sum[c]  = {1'b0, dstart[c]} + SUM_W'(cfg.qualify_delay[c]);
      remind_sum[c] = {1'b0, lastrem[c]} + SUM_W'(cfg.reminder_period);
      has_delay[c]  = (cfg.qualify_delay[c] != '0);
    end
  end

  always_comb begin
    for (int c = 0; c < dtaq_pkg::MAX_CH; c++) begin
      ev[c]           = dtaq_pkg::EV_NONE;
      act[c]          = 1'b0;
      crossed_next[c] = crossed[c];
      running_next[c] = running[c];
      dstart_next[c]  = dstart[c];
      lastrem_next[c] = lastrem[c];
      if (c < NUM_ACT) begin
        if (q_data.above[c]) begin
          if (has_delay[c] && !running[c]) begin
            running_next[c] = 1'b1;
            dstart_next[c]  = q_data.time_ms;
          end else if (!(has_delay[c] && (delay_sum[c] > t_ext))) begin
            act[c]          = 1'b1;
            crossed_next[c] = 1'b1;
            if (!crossed[c]) begin
              ev[c]           = dtaq_pkg::EV_START;
              lastrem_next[c] = q_data.time_ms;
            end else if (remind_sum[c] < t_ext) begin
              ev[c]           = dtaq_pkg::EV_CONTINUE;
              lastrem_next[c] = q_data.time_ms;
            end
          end
        end else begin
          running_next[c] = 1'b0;
          if (crossed[c]) begin
            ev[c]           = dtaq_pkg::EV_END;
            crossed_next[c] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    // Channel two outranks channel one.
    if (act[1]) begin
      out_data.alert_level = dtaq_pkg::LVL_DANGER;
    end else if (act[0]) begin
      out_data.alert_level = dtaq_pkg::LVL_ELEVATED;
    end else begin
      out_data.alert_level = dtaq_pkg::LVL_OK;
    end
    out_data.event_one_kind = cfg.report_enable[0] ? ev[0] : dtaq_pkg::EV_NONE;
    out_data.event_two_kind = cfg.report_enable[1] ? ev[1] : dtaq_pkg::EV_NONE;
    out_data.event_value    = q_data.sample_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crossed <= '0;
      running <= '0;
    end else if (go) begin
      crossed <= crossed_next;
      running <= running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dstart  <= dstart_next;
      lastrem <= lastrem_next;
    end
  end

  a_start_sets_crossed: assert property (@(posedge clk) disable iff (rst)
    (out_push && out_data.event_one_kind == dtaq_pkg::EV_START) |=> crossed[0])
    else $error("start event on channel one did not leave it crossed");

  a_end_clears_crossed: assert property (@(posedge clk) disable iff (rst)
    (out_push && out_data.event_two_kind == dtaq_pkg::EV_END) |=> !crossed[1])
    else $error("end event on channel two left it crossed");

  a_danger_means_crossed: assert property (@(posedge clk) disable iff (rst)
    (out_push && out_data.alert_level == dtaq_pkg::LVL_DANGER) |=> crossed[1])
    else $error("danger level without channel two crossed");

  a_cross_only_on_item: assert property (@(posedge clk) disable iff (rst)
    $rose(crossed[0]) |-> $past(out_push))
    else $error("channel one crossed without an item");

endmodule

// ===== rtl/core/dual_threshold_alarm_qualifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_threshold_alarm_qualifier: two-channel sensor alarm with delay
// Qualifies samples against two thresholds and reports start, continue and
// end events together with an alert level.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  sample    in         push / full               sample_t
//  result    out        pop / empty               result_t
//  config    in/out     psel, penable, pwrite     paddr, pwdata, prdata
//
//  One item per cycle sustained while the result queue is not full; a result
//  passes through the front queue, then the back part into the result queue,
//  where it is shown and can be popped.
//  The per-channel state update in the back part sets that rate: each item
//  reads the state left by the one before it.
//  Reset clears channel state and sets the registers to their defaults.
//  With pop held low, up to four items wait in the two queues before full.
// ----------------------------------------------------------------------------
module dual_threshold_alarm_qualifier #(
  parameter int unsigned NUM_CHANNELS = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  dtaq_pkg::sample_t           sample,
  output logic                        full,
  input  logic                        pop,
  output dtaq_pkg::result_t           result,
  output logic                        empty,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dtaq_pkg::ADDR_W-1:0] paddr,
  input  logic [dtaq_pkg::DATA_W-1:0] pwdata,
  output logic [dtaq_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned NUM_ACT =
    (NUM_CHANNELS < dtaq_pkg::MAX_CH) ? NUM_CHANNELS : dtaq_pkg::MAX_CH;
  localparam int unsigned WORK_W = $bits(dtaq_pkg::work_t);
  localparam int unsigned RES_W  = $bits(dtaq_pkg::result_t);

  dtaq_pkg::cfg_t    cfg;
  logic              mid_push;
  logic              mid_full;
  logic              mid_pop;
  logic              mid_empty;
  dtaq_pkg::work_t   mid_wdata;
  logic [WORK_W-1:0] mid_rdata;
  logic              out_push;
  logic              out_full;
  dtaq_pkg::result_t out_wdata;
  logic [RES_W-1:0]  out_rdata;

  dtaq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtaq_front #(
    .NUM_ACT (NUM_ACT)
  ) u_front (
    .push   (push),
    .sample (sample),
    .full   (full),
    .cfg    (cfg),
    .q_full (mid_full),
    .q_push (mid_push),
    .q_data (mid_wdata)
  );

  dtaq_fifo #(
    .WIDTH (WORK_W),
    .DEPTH (dtaq_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  dtaq_back #(
    .NUM_ACT (NUM_ACT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (mid_empty),
    .q_data   (dtaq_pkg::work_t'(mid_rdata)),
    .q_pop    (mid_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_data (out_wdata)
  );

  dtaq_fifo #(
    .WIDTH (RES_W),
    .DEPTH (dtaq_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign result = dtaq_pkg::result_t'(out_rdata);

endmodule
